/* design/trcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package trcs_pkg;

  localparam int RING_MAX = 4;
  localparam int LINKS_PER_NODE = 6;
  localparam int MAX_HOPS = 3;
  localparam int COORD_W = 2;
  localparam int NODE_W = 3 * COORD_W;
  localparam int NODE_COUNT = RING_MAX * RING_MAX * RING_MAX;
  localparam int SLOT_COUNT = NODE_COUNT * LINKS_PER_NODE;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int USAGE_W = 16;
  localparam int COST_W = 28;
  localparam int PROD_W = USAGE_W + 8;

  localparam logic [USAGE_W-1:0] USAGE_FULL = 16'hFFFF;
  localparam logic [2:0] LINK_LAST = 3'd5;
  localparam logic [2:0] SIZE_CAP = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  typedef struct packed {
    logic       kind;
    logic [1:0] src_x;
    logic [1:0] src_y;
    logic [1:0] src_z;
    logic [1:0] dst_x;
    logic [1:0] dst_y;
    logic [1:0] dst_z;
  } route_in_t;

  typedef struct packed {
    logic              routed;
    logic [1:0]        hop_count;
    logic [2:0]        hop_first;
    logic [2:0]        hop_second;
    logic [2:0]        hop_third;
    logic [COST_W-1:0] route_cost;
  } route_out_t;

  // index 0 is x, 1 is y, 2 is z
  typedef logic [2:0][COORD_W-1:0] coord_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CAND,
    S_HOP_START,
    S_HOP_RUN,
    S_DONE,
    S_NEXT,
    S_UPD_RD,
    S_UPD_WR,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_RING_X      = 3'd0,
    REG_RING_Y      = 3'd1,
    REG_RING_Z      = 3'd2,
    REG_LINK_COST   = 3'd3,
    REG_USAGE_WT    = 3'd4,
    REG_RING_CHANGE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

  function automatic logic [NODE_W-1:0] node_of(coord_t c);
    return {c[2], c[1], c[0]};
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(coord_t c, logic [2:0] link);
    logic [SLOT_W-1:0] n;
    n = SLOT_W'(node_of(c));
    return (n << 2) + (n << 1) + SLOT_W'(link);
  endfunction

  function automatic coord_t with_axis(coord_t c, logic [1:0] axis, logic [COORD_W-1:0] v);
    coord_t q;
    q = c;
    case (axis)
      2'd0:    q[0] = v;
      2'd1:    q[1] = v;
      2'd2:    q[2] = v;
      default: q = c;
    endcase
    return q;
  endfunction

  function automatic logic [2:0] ring_len(logic [2:0] size);
    return (size > SIZE_CAP) ? SIZE_CAP : size;
  endfunction

endpackage

`default_nettype wire

/* design/trcs_usage_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module trcs_usage_mem (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [trcs_pkg::SLOT_W-1:0]  waddr,
  input  wire logic [trcs_pkg::USAGE_W-1:0] wdata,
  input  wire logic [trcs_pkg::SLOT_W-1:0]  raddr,
  output logic      [trcs_pkg::USAGE_W-1:0] rdata
);
  import trcs_pkg::*;

  logic [USAGE_W-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/trcs_cost_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module trcs_cost_mac (
  input  wire logic                        clk,
  input  wire trcs_pkg::mac_ctrl_t          ctrl,
  input  wire logic [trcs_pkg::USAGE_W-1:0] usage,
  input  wire logic [7:0]                   weight,
  input  wire logic [7:0]                   link_cost,
  output logic      [trcs_pkg::COST_W-1:0]  acc
);
  import trcs_pkg::*;

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(usage) * PROD_W'(weight);
    end
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + COST_W'(link_cost) + COST_W'(prod);
    end
  end

endmodule

`default_nettype wire

/* design/torus_route_cost_search.sv */
`timescale 1ns / 1ps
`default_nettype none

// Route cost search over up to three rings. After reset the block zeroes every slot of
// the link usage RAM and holds in_stall high meanwhile. A disable beat goes straight to
// the result. A route beat walks every link sequence of the k differing axes (6^k
// candidates, illegal ones skipped one per cycle); each legal sequence (at most 48) is
// priced hop by hop through the single usage RAM read port and the shared
// multiply-accumulate, one read per ring node of the hop. The winner then gets a
// saturating usage increment on each ring node of its hops.
// One beat is in work at a time; a finished result waits in the output register.
module torus_route_cost_search (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire trcs_pkg::route_in_t    in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output trcs_pkg::route_out_t        out_data,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [4:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);
  import trcs_pkg::*;

  state_t state, state_next;

  logic [2:0] size_x, size_y, size_z;
  logic [7:0] link_cost, usage_weight, ring_change_cost;

  coord_t src, dst, cur;
  logic [2:0] mask;
  logic [1:0] k;
  logic [2:0][2:0] dig, best_dig, dig_next;
  logic have_best;
  logic [COST_W-1:0] spent, best_cost;
  logic [1:0] hop;
  logic [2:0] ir;
  logic v1, v2;
  logic [SLOT_W-1:0] clr_cnt;
  logic [NODE_COUNT-1:0] node_off;
  logic ring_bad;
  route_out_t res;

  logic accept, wr_cfg;
  coord_t in_src, in_dst;
  logic [2:0] in_mask;
  logic in_fail;
  logic upd_phase;
  logic [2:0] link_sel, cur_n;
  logic [1:0] cur_axis;
  logic hop_bad, ring_hit, cand_ok, last, issue, hop_last;
  logic [SLOT_W-1:0] q_addr;
  logic mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [USAGE_W-1:0] mem_wdata, mem_rdata;
  logic [COST_W-1:0] acc;
  mac_ctrl_t mac_ctrl;
  state_t adv_state;

  function automatic logic [2:0] axis_len(logic [1:0] a, logic [2:0] sx, logic [2:0] sy,
                                          logic [2:0] sz);
    logic [2:0] n;
    case (a)
      2'd0:    n = ring_len(sx);
      2'd1:    n = ring_len(sy);
      2'd2:    n = ring_len(sz);
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite && pready;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 3'd3;
      size_y <= 3'd3;
      size_z <= 3'd0;
      link_cost <= 8'd1;
      usage_weight <= 8'd1;
      ring_change_cost <= 8'd1;
    end else if (wr_cfg) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_RING_X:      size_x <= pwdata[2:0];
        REG_RING_Y:      size_y <= pwdata[2:0];
        REG_RING_Z:      size_z <= pwdata[2:0];
        REG_LINK_COST:   link_cost <= pwdata[7:0];
        REG_USAGE_WT:    usage_weight <= pwdata[7:0];
        REG_RING_CHANGE: ring_change_cost <= pwdata[7:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_RING_X:      prdata = {29'd0, size_x};
      REG_RING_Y:      prdata = {29'd0, size_y};
      REG_RING_Z:      prdata = {29'd0, size_z};
      REG_LINK_COST:   prdata = {24'd0, link_cost};
      REG_USAGE_WT:    prdata = {24'd0, usage_weight};
      REG_RING_CHANGE: prdata = {24'd0, ring_change_cost};
      default:         prdata = '0;
    endcase
  end

  // decode of an incoming beat
  always_comb begin
    in_src = {in_data.src_z, in_data.src_y, in_data.src_x};
    in_dst = {in_data.dst_z, in_data.dst_y, in_data.dst_x};
    in_fail = 1'b0;
    for (int a = 0; a < 3; a++) begin
      in_mask[a] = (in_src[a] != in_dst[a]) &&
                   (axis_len(2'(a), size_x, size_y, size_z) != 3'd0);
      if ((in_src[a] != in_dst[a]) && (axis_len(2'(a), size_x, size_y, size_z) == 3'd0)) begin
        in_fail = 1'b1;
      end
    end
  end

  // current hop
  assign upd_phase = (state == S_UPD_RD) || (state == S_UPD_WR);
  assign link_sel = upd_phase ? best_dig[hop] : dig[hop];
  assign cur_axis = link_sel[2:1];
  assign cur_n = axis_len(cur_axis, size_x, size_y, size_z);
  assign q_addr = slot_of(with_axis(cur, cur_axis, ir[1:0]), link_sel);
  assign issue = (state == S_HOP_RUN) && (ir < cur_n);
  assign hop_last = (hop == (k - 2'd1));

  // source node checked at hop start, ring nodes one per issue cycle
  assign hop_bad = node_off[node_of(cur)];
  assign ring_hit = node_off[node_of(with_axis(cur, cur_axis, ir[1:0]))];

  // legality of the candidate and the next one in ascending link order
  always_comb begin
    logic [3:0] used, mask4;
    logic [1:0] a;
    logic carry;
    used = '0;
    mask4 = {1'b0, mask};
    cand_ok = 1'b1;
    for (int j = 0; j < MAX_HOPS; j++) begin
      a = dig[j][2:1];
      if (j < int'(k)) begin
        if (!mask4[a] || used[a]) begin
          cand_ok = 1'b0;
        end
        used[a] = 1'b1;
      end
    end
    dig_next = dig;
    carry = 1'b1;
    for (int j = MAX_HOPS - 1; j >= 0; j--) begin
      if ((j < int'(k)) && carry) begin
        if (dig_next[j] == LINK_LAST) begin
          dig_next[j] = 3'd0;
        end else begin
          dig_next[j] = dig_next[j] + 3'd1;
          carry = 1'b0;
        end
      end
    end
    last = carry;
  end

  always_comb begin
    if (!last) begin
      adv_state = S_CAND;
    end else if (have_best && (k != 2'd0)) begin
      adv_state = S_UPD_RD;
    end else begin
      adv_state = S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_ctrl = '{clr: (state == S_HOP_START), mul_en: v1, acc_en: v2};
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == SLOT_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (in_data.kind || in_fail) ? S_OUT : S_CAND;
        end
      end
      S_CAND: begin
        if (k == 2'd0) state_next = S_DONE;
        else if (cand_ok) state_next = S_HOP_START;
        else state_next = adv_state;
      end
      S_HOP_START: begin
        state_next = hop_bad ? S_NEXT : S_HOP_RUN;
      end
      S_HOP_RUN: begin
        if (!issue && !v1 && !v2) begin
          if (ring_bad) state_next = S_NEXT;
          else state_next = hop_last ? S_DONE : S_HOP_START;
        end
      end
      S_DONE:   state_next = S_NEXT;
      S_NEXT:   state_next = adv_state;
      S_UPD_RD: state_next = S_UPD_WR;
      S_UPD_WR: begin
        if ((ir + 3'd1 == cur_n) && hop_last) state_next = S_OUT;
        else state_next = S_UPD_RD;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // usage RAM port
  assign mem_we = (state == S_CLEAR) || (state == S_UPD_WR);
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : q_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 :
                     ((mem_rdata == USAGE_FULL) ? mem_rdata : mem_rdata + 16'd1);

  trcs_usage_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (q_addr),
    .rdata (mem_rdata)
  );

  trcs_cost_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .usage     (mem_rdata),
    .weight    (usage_weight),
    .link_cost (link_cost),
    .acc       (acc)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      node_off <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      have_best <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + SLOT_W'(1);
      if (accept && in_data.kind) node_off[node_of(in_src)] <= 1'b1;
      if (accept) begin
        have_best <= 1'b0;
      end else if ((state == S_DONE) && (!have_best || (spent < best_cost))) begin
        have_best <= 1'b1;
      end
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_stall == 1'b0) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      src <= in_src;
      dst <= in_dst;
      mask <= in_mask;
      k <= 2'({1'b0, in_mask[0]} + {1'b0, in_mask[1]} + {1'b0, in_mask[2]});
      dig <= '0;
      res <= '0;
    end
    if (state == S_CAND) begin
      hop <= '0;
      cur <= src;
      spent <= '0;
      if (!cand_ok && (k != 2'd0)) dig <= dig_next;
    end
    if (state == S_NEXT) dig <= dig_next;
    if ((state == S_HOP_START) || ((state_next == S_UPD_RD) && (state != S_UPD_WR))) begin
      ir <= '0;
    end
    if (state == S_HOP_START) ring_bad <= 1'b0;
    if (issue && ring_hit) ring_bad <= 1'b1;
    if (issue) ir <= ir + 3'd1;
    if ((state == S_HOP_RUN) && !issue && !v1 && !v2) begin
      spent <= spent + acc + COST_W'(ring_change_cost);
      cur <= with_axis(cur, cur_axis, dst[cur_axis]);
      hop <= hop + 2'd1;
    end
    if ((state == S_DONE) && (!have_best || (spent < best_cost))) begin
      best_cost <= spent;
      best_dig <= dig;
    end
    // start the usage update of the winner
    if ((state == S_NEXT) && (state_next == S_UPD_RD)) begin
      hop <= '0;
      cur <= src;
    end
    if (state == S_UPD_WR) begin
      if (ir + 3'd1 == cur_n) begin
        ir <= '0;
        cur <= with_axis(cur, cur_axis, dst[cur_axis]);
        hop <= hop + 2'd1;
      end else begin
        ir <= ir + 3'd1;
      end
    end
    if ((state_next == S_OUT) && (state != S_IDLE) && (state != S_OUT)) begin
      if (have_best || (state == S_UPD_WR)) begin
        res.routed <= 1'b1;
        res.hop_count <= k;
        res.hop_first <= (k > 2'd0) ? best_dig[0] + 3'd1 : 3'd0;
        res.hop_second <= (k > 2'd1) ? best_dig[1] + 3'd1 : 3'd0;
        res.hop_third <= (k > 2'd2) ? best_dig[2] + 3'd1 : 3'd0;
        res.route_cost <= best_cost;
      end else begin
        res <= '0;
      end
    end
    if ((state == S_OUT) && (!out_valid || !out_stall)) out_data <= res;
  end

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOP_RUN) |-> !mem_we)
    else $error("usage RAM written during pricing");

  a_disable_to_out: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.kind) |=> (state == S_OUT))
    else $error("disable beat did not go straight to result");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("accumulate without preceding multiply");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.routed) |-> ((out_data.route_cost == '0) &&
                                         (out_data.hop_count == 2'd0)))
    else $error("unrouted result carries nonzero fields");

endmodule

`default_nettype wire
